[rtl/x86_64_instruction_encoder_top_assert.svh]
// ---------------------------------------------------------------------------
// x86-64 encoder assertion macros
// Shared property forms used by the encoder checker.
// ---------------------------------------------------------------------------
`ifndef X86_64_INSTRUCTION_ENCODER_TOP_ASSERT_SVH
`define X86_64_INSTRUCTION_ENCODER_TOP_ASSERT_SVH

// same-cycle implication
`define X64ENC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define X64ENC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/x64enc_pkg.sv]
// ---------------------------------------------------------------------------
// x64enc_pkg
// Command codes, opcodes, result type and range helpers for the encoder.
// ---------------------------------------------------------------------------
package x64enc_pkg;

  localparam int MAX_BYTES = 10;
  localparam int LEN_W     = $clog2(MAX_BYTES + 1);

  localparam logic [4:0] CMD_RET      = 5'd0;
  localparam logic [4:0] CMD_LEAVE    = 5'd1;
  localparam logic [4:0] CMD_PUSHF    = 5'd2;
  localparam logic [4:0] CMD_POPF     = 5'd3;
  localparam logic [4:0] CMD_PUSH_REG = 5'd4;
  localparam logic [4:0] CMD_POP_REG  = 5'd5;
  localparam logic [4:0] CMD_PUSH_IMM = 5'd6;
  localparam logic [4:0] CMD_LEA      = 5'd7;
  localparam logic [4:0] CMD_SUB      = 5'd8;
  localparam logic [4:0] CMD_ADD      = 5'd9;
  localparam logic [4:0] CMD_AND      = 5'd10;
  localparam logic [4:0] CMD_MOV_RR   = 5'd11;
  localparam logic [4:0] CMD_MOV_IMM  = 5'd12;
  localparam logic [4:0] CMD_LOAD     = 5'd13;
  localparam logic [4:0] CMD_JMP_REG  = 5'd14;
  localparam logic [4:0] CMD_JMP_MEM  = 5'd15;
  localparam logic [4:0] CMD_CALL_REG = 5'd16;
  localparam logic [4:0] CMD_CALL_MEM = 5'd17;

  localparam logic [7:0] OP_REX      = 8'h40;
  localparam logic [7:0] OP_REX_W    = 8'h48;
  localparam logic [7:0] OP_REX_B    = 8'h41;
  localparam logic [7:0] OP_ALU_I8   = 8'h83;
  localparam logic [7:0] OP_ALU_I32  = 8'h81;
  localparam logic [7:0] OP_LEA      = 8'h8d;
  localparam logic [7:0] OP_LOAD     = 8'h8b;
  localparam logic [7:0] OP_MOV_RR   = 8'h89;
  localparam logic [7:0] OP_MOV_RI   = 8'hb8;
  localparam logic [7:0] OP_MOV_RM_I = 8'hc7;
  localparam logic [7:0] OP_RET      = 8'hc3;
  localparam logic [7:0] OP_RET_I16  = 8'hc2;
  localparam logic [7:0] OP_LEAVE    = 8'hc9;
  localparam logic [7:0] OP_PUSHF    = 8'h9c;
  localparam logic [7:0] OP_POPF     = 8'h9d;
  localparam logic [7:0] OP_PUSH_R   = 8'h50;
  localparam logic [7:0] OP_POP_R    = 8'h58;
  localparam logic [7:0] OP_PUSH_I8  = 8'h6a;
  localparam logic [7:0] OP_PUSH_I32 = 8'h68;
  localparam logic [7:0] OP_GRP5     = 8'hff;

  localparam logic [2:0] DIGIT_ADD  = 3'd0;
  localparam logic [2:0] DIGIT_CALL = 3'd2;
  localparam logic [2:0] DIGIT_AND  = 3'd4;
  localparam logic [2:0] DIGIT_JMP  = 3'd4;
  localparam logic [2:0] DIGIT_SUB  = 3'd5;

  localparam logic [2:0] RM_SIB  = 3'd4;
  localparam logic [2:0] RM_DISP = 3'd5;
  localparam logic [3:0] IDX_NONE = 4'd4;

  typedef logic [MAX_BYTES-1:0][7:0] byte_vec_t;

  typedef struct packed {
    byte_vec_t        bytes;
    logic [LEN_W-1:0] len;
    logic             err;
  } enc_res_t;

  function automatic logic fits_imm8(input logic [63:0] v);
    return (v + 64'd127) <= 64'd254;
  endfunction

  function automatic logic fits_imm32(input logic [63:0] v);
    return (v + 64'h0000_0000_7fff_ffff) <= 64'h0000_0000_ffff_fffe;
  endfunction

  function automatic logic fits_u32(input logic [63:0] v);
    return v[63:32] == 32'd0;
  endfunction

endpackage

[rtl/x86_64_instruction_encoder_top.sv]
// ---------------------------------------------------------------------------
// x86_64_instruction_encoder_top
// x86-64 machine-code encoder: one request in, its bytes out one per beat.
// ---------------------------------------------------------------------------
// Input channel (in_*): one beat is one request (command, registers, scale,
// index, base and a 64-bit immediate or displacement). Output channel
// (out_*): one beat per code byte; out_last_byte marks the final byte. An
// immediate out of range gives a single beat with byte 0, last and
// out_range_error set. An unknown command gives no beats.
// Path: a taken request goes to the input register, then loads into the
// byte buffer, from which the first byte is shown.
// Throughput: one byte per cycle while out_stall is low. A request holds
// the byte buffer until its last byte is taken; the next request loads in
// the cycle its last byte is taken, so instructions follow with no gap. An
// unknown command still takes a buffer load slot; byte output sets the rate.
// Reset (synchronous, rst_n low) empties the input register and the byte
// buffer. When the receiver stalls, the current byte holds; once the input
// register is also full, in_stall rises.
// ---------------------------------------------------------------------------
module x86_64_instruction_encoder_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [4:0]          in_cmd,
  input  logic [3:0]          in_dest_reg,
  input  logic [3:0]          in_source_reg,
  input  logic [3:0]          in_scale_factor,
  input  logic signed [4:0]   in_index_reg,
  input  logic signed [5:0]   in_base_reg,
  input  logic signed [63:0]  in_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_code_byte,
  output logic                out_last_byte,
  output logic                out_range_error
);

  logic                          req_vld_r;
  logic [4:0]                    cmd_r;
  logic [3:0]                    dest_r;
  logic [3:0]                    src_r;
  logic [3:0]                    scale_r;
  logic signed [4:0]             index_r;
  logic signed [5:0]             base_r;
  logic signed [63:0]            value_r;

  x64enc_pkg::enc_res_t          enc;
  x64enc_pkg::byte_vec_t         buf_r, buf_nxt;
  logic [x64enc_pkg::LEN_W-1:0]  cnt_r, cnt_nxt;
  logic                          err_r, err_nxt;
  logic                          out_take, buf_free, load;

  x64enc_encode u_encode (
    .cmd          (cmd_r),
    .dest_reg     (dest_r),
    .source_reg   (src_r),
    .scale_factor (scale_r),
    .index_reg    (index_r),
    .base_reg     (base_r),
    .value        (value_r),
    .res          (enc)
  );

  assign out_take = out_valid & ~out_stall;
  assign buf_free = (cnt_r == '0) |
                    (out_take & (cnt_r == x64enc_pkg::LEN_W'(1)));
  assign load     = req_vld_r & buf_free;
  assign in_stall = req_vld_r & ~buf_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else if (!in_stall) begin
      req_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r   <= in_cmd;
      dest_r  <= in_dest_reg;
      src_r   <= in_source_reg;
      scale_r <= in_scale_factor;
      index_r <= in_index_reg;
      base_r  <= in_base_reg;
      value_r <= in_value;
    end
  end

  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    err_nxt = err_r;
    if (load) begin
      buf_nxt = enc.bytes;
      cnt_nxt = enc.len;
      err_nxt = enc.err;
    end else if (out_take) begin
      buf_nxt = buf_r >> 8;
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    err_r <= err_nxt;
  end

  assign out_valid       = cnt_r != '0;
  assign out_code_byte   = buf_r[0];
  assign out_last_byte   = cnt_r == x64enc_pkg::LEN_W'(1);
  assign out_range_error = err_r;

endmodule

[rtl/x64enc_encode.sv]
// ---------------------------------------------------------------------------
// x64enc_encode
// Turns one registered request into its machine-code bytes and length.
// ---------------------------------------------------------------------------
module x64enc_encode (
  input  logic [4:0]              cmd,
  input  logic [3:0]              dest_reg,
  input  logic [3:0]              source_reg,
  input  logic [3:0]              scale_factor,
  input  logic signed [4:0]       index_reg,
  input  logic signed [5:0]       base_reg,
  input  logic signed [63:0]      value,
  output x64enc_pkg::enc_res_t    res
);

  logic       f8, f32, u32;
  logic       mem_w;
  logic [3:0] mem_r;
  logic [7:0] mem_opc;
  logic       sc_v;
  logic [1:0] sc, sc3;
  logic       idx_v, idx_v2, idx_v3;
  logic [3:0] idx_n, idx2, idx3;
  logic       base_none, base_rip, base12;
  logic [3:0] base_n;
  logic       force_a, force_b, sib, rex_x, rex_b;
  logic       mem_rex_en, mem_sib_en;
  logic [7:0] mem_rex, mem_modrm, mem_sib;
  logic [2:0] mem_disp;

  assign f8  = x64enc_pkg::fits_imm8(value);
  assign f32 = x64enc_pkg::fits_imm32(value);
  assign u32 = x64enc_pkg::fits_u32(value);

  always_comb begin
    case (cmd)
      x64enc_pkg::CMD_LEA: begin
        mem_w = 1'b1; mem_r = dest_reg; mem_opc = x64enc_pkg::OP_LEA;
      end
      x64enc_pkg::CMD_LOAD: begin
        mem_w = 1'b1; mem_r = dest_reg; mem_opc = x64enc_pkg::OP_LOAD;
      end
      x64enc_pkg::CMD_JMP_MEM: begin
        mem_w = 1'b0; mem_r = {1'b0, x64enc_pkg::DIGIT_JMP}; mem_opc = x64enc_pkg::OP_GRP5;
      end
      x64enc_pkg::CMD_CALL_MEM: begin
        mem_w = 1'b0; mem_r = {1'b0, x64enc_pkg::DIGIT_CALL}; mem_opc = x64enc_pkg::OP_GRP5;
      end
      default: begin
        mem_w = 1'b0; mem_r = 4'd0; mem_opc = 8'd0;
      end
    endcase
  end

  always_comb begin
    case (scale_factor)
      4'd1:    begin sc_v = 1'b1; sc = 2'd0; end
      4'd2:    begin sc_v = 1'b1; sc = 2'd1; end
      4'd4:    begin sc_v = 1'b1; sc = 2'd2; end
      4'd8:    begin sc_v = 1'b1; sc = 2'd3; end
      default: begin sc_v = 1'b0; sc = 2'd0; end
    endcase
  end

  assign idx_v     = ~index_reg[4];
  assign idx_n     = index_reg[3:0];
  assign base_none = base_reg[5];
  assign base_rip  = base_reg == 6'sd16;
  assign base_n    = base_reg[3:0];
  assign base12    = ~base_none & ~base_rip & (base_n == 4'd12);

  assign force_a = (idx_v | base12) & ~sc_v;
  assign idx_v2  = idx_v | force_a;
  assign idx2    = force_a ? x64enc_pkg::IDX_NONE : idx_n;
  assign sib     = idx_v2 | base_none | (base_n[2:0] == x64enc_pkg::RM_SIB);
  assign force_b = sib & (~idx_v2 | ~sc_v);
  assign idx3    = force_b ? x64enc_pkg::IDX_NONE : idx2;
  assign sc3     = force_b ? 2'd0 : sc;
  assign idx_v3  = idx_v2 | force_b;
  assign rex_x   = idx_v3 & idx3[3];
  assign rex_b   = ~base_none & base_n[3];

  always_comb begin
    mem_sib = {sc3, idx3[2:0], base_none ? x64enc_pkg::RM_DISP : base_n[2:0]};
    if (base_rip) begin
      mem_rex_en = mem_w | mem_r[3] | (idx_v & idx_n[3]);
      mem_rex    = x64enc_pkg::OP_REX | {4'd0, mem_w, mem_r[3], 2'b00};
      mem_modrm  = {2'b00, mem_r[2:0], x64enc_pkg::RM_DISP};
      mem_sib_en = 1'b0;
      mem_disp   = 3'd4;
    end else begin
      mem_rex_en = mem_w | mem_r[3] | rex_x | rex_b;
      mem_rex    = x64enc_pkg::OP_REX | {4'd0, mem_w, mem_r[3], rex_x, rex_b};
      mem_sib_en = sib;
      if (!sib) begin
        if (value == 64'sd0 && base_n[2:0] != x64enc_pkg::RM_DISP) begin
          mem_modrm = {2'b00, mem_r[2:0], base_n[2:0]};
          mem_disp  = 3'd0;
        end else begin
          mem_modrm = {f8 ? 2'b01 : 2'b10, mem_r[2:0], base_n[2:0]};
          mem_disp  = f8 ? 3'd1 : 3'd4;
        end
      end else begin
        mem_modrm = {base_none ? 2'b00 : (f8 ? 2'b01 : 2'b10), mem_r[2:0],
                     x64enc_pkg::RM_SIB};
        mem_disp  = (f8 && !base_none) ? 3'd1 : 3'd4;
      end
    end
  end

  always_comb begin
    x64enc_pkg::byte_vec_t       b;
    logic [x64enc_pkg::LEN_W-1:0] n;
    logic                        err;
    b   = '0;
    n   = '0;
    err = 1'b0;
    case (cmd)
      x64enc_pkg::CMD_RET: begin
        if (value[15:0] == 16'd0) begin
          b[n] = x64enc_pkg::OP_RET; n = n + 1'b1;
        end else begin
          b[n] = x64enc_pkg::OP_RET_I16; n = n + 1'b1;
          b[n] = value[7:0];             n = n + 1'b1;
          b[n] = value[15:8];            n = n + 1'b1;
        end
      end
      x64enc_pkg::CMD_LEAVE: begin
        b[n] = x64enc_pkg::OP_LEAVE; n = n + 1'b1;
      end
      x64enc_pkg::CMD_PUSHF: begin
        b[n] = x64enc_pkg::OP_PUSHF; n = n + 1'b1;
      end
      x64enc_pkg::CMD_POPF: begin
        b[n] = x64enc_pkg::OP_POPF; n = n + 1'b1;
      end
      x64enc_pkg::CMD_PUSH_REG, x64enc_pkg::CMD_POP_REG: begin
        if (dest_reg[3]) begin
          b[n] = x64enc_pkg::OP_REX_B; n = n + 1'b1;
        end
        b[n] = ((cmd == x64enc_pkg::CMD_PUSH_REG) ? x64enc_pkg::OP_PUSH_R
                                                  : x64enc_pkg::OP_POP_R)
               | {5'd0, dest_reg[2:0]};
        n = n + 1'b1;
      end
      x64enc_pkg::CMD_PUSH_IMM: begin
        if (f8) begin
          b[n] = x64enc_pkg::OP_PUSH_I8; n = n + 1'b1;
          b[n] = value[7:0];             n = n + 1'b1;
        end else if (u32) begin
          b[n] = x64enc_pkg::OP_PUSH_I32; n = n + 1'b1;
          for (int k = 0; k < 4; k++) begin
            b[n] = value[8*k +: 8]; n = n + 1'b1;
          end
        end else begin
          err = 1'b1;
        end
      end
      x64enc_pkg::CMD_SUB, x64enc_pkg::CMD_ADD, x64enc_pkg::CMD_AND: begin
        if (!f8 && !f32) begin
          err = 1'b1;
        end else begin
          b[n] = x64enc_pkg::OP_REX_W | {7'd0, dest_reg[3]}; n = n + 1'b1;
          b[n] = f8 ? x64enc_pkg::OP_ALU_I8 : x64enc_pkg::OP_ALU_I32; n = n + 1'b1;
          b[n] = {2'b11,
                  (cmd == x64enc_pkg::CMD_SUB) ? x64enc_pkg::DIGIT_SUB :
                  (cmd == x64enc_pkg::CMD_ADD) ? x64enc_pkg::DIGIT_ADD :
                                                 x64enc_pkg::DIGIT_AND,
                  dest_reg[2:0]};
          n = n + 1'b1;
          if (f8) begin
            b[n] = value[7:0]; n = n + 1'b1;
          end else begin
            for (int k = 0; k < 4; k++) begin
              b[n] = value[8*k +: 8]; n = n + 1'b1;
            end
          end
        end
      end
      x64enc_pkg::CMD_MOV_RR: begin
        b[n] = x64enc_pkg::OP_REX_W | {5'd0, source_reg[3], 1'b0, dest_reg[3]};
        n = n + 1'b1;
        b[n] = x64enc_pkg::OP_MOV_RR; n = n + 1'b1;
        b[n] = {2'b11, source_reg[2:0], dest_reg[2:0]}; n = n + 1'b1;
      end
      x64enc_pkg::CMD_MOV_IMM: begin
        if (u32) begin
          if (dest_reg[3]) begin
            b[n] = x64enc_pkg::OP_REX_B; n = n + 1'b1;
          end
          b[n] = x64enc_pkg::OP_MOV_RI | {5'd0, dest_reg[2:0]}; n = n + 1'b1;
        end else if (f32) begin
          b[n] = x64enc_pkg::OP_REX_W | {7'd0, dest_reg[3]}; n = n + 1'b1;
          b[n] = x64enc_pkg::OP_MOV_RM_I;                     n = n + 1'b1;
          b[n] = {2'b11, 3'd0, dest_reg[2:0]};                n = n + 1'b1;
        end else begin
          b[n] = x64enc_pkg::OP_REX_W | {7'd0, dest_reg[3]};   n = n + 1'b1;
          b[n] = x64enc_pkg::OP_MOV_RI | {5'd0, dest_reg[2:0]}; n = n + 1'b1;
        end
        for (int k = 0; k < 4; k++) begin
          b[n] = value[8*k +: 8]; n = n + 1'b1;
        end
        if (!u32 && !f32) begin
          for (int k = 4; k < 8; k++) begin
            b[n] = value[8*k +: 8]; n = n + 1'b1;
          end
        end
      end
      x64enc_pkg::CMD_JMP_REG, x64enc_pkg::CMD_CALL_REG: begin
        if (dest_reg[3]) begin
          b[n] = x64enc_pkg::OP_REX_B; n = n + 1'b1;
        end
        b[n] = x64enc_pkg::OP_GRP5; n = n + 1'b1;
        b[n] = {2'b11,
                (cmd == x64enc_pkg::CMD_JMP_REG) ? x64enc_pkg::DIGIT_JMP
                                                 : x64enc_pkg::DIGIT_CALL,
                dest_reg[2:0]};
        n = n + 1'b1;
      end
      x64enc_pkg::CMD_LEA, x64enc_pkg::CMD_LOAD,
      x64enc_pkg::CMD_JMP_MEM, x64enc_pkg::CMD_CALL_MEM: begin
        if (mem_rex_en) begin
          b[n] = mem_rex; n = n + 1'b1;
        end
        b[n] = mem_opc;   n = n + 1'b1;
        b[n] = mem_modrm; n = n + 1'b1;
        if (mem_sib_en) begin
          b[n] = mem_sib; n = n + 1'b1;
        end
        if (mem_disp == 3'd1) begin
          b[n] = value[7:0]; n = n + 1'b1;
        end else if (mem_disp == 3'd4) begin
          for (int k = 0; k < 4; k++) begin
            b[n] = value[8*k +: 8]; n = n + 1'b1;
          end
        end
      end
      default: begin
        n = '0;
      end
    endcase
    if (err) begin
      b = '0;
      n = x64enc_pkg::LEN_W'(1);
    end
    res.bytes = b;
    res.len   = n;
    res.err   = err;
  end

endmodule

[rtl/x64enc_checker.sv]
// ---------------------------------------------------------------------------
// x64enc_checker
// Port-level checks on the encoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "x86_64_instruction_encoder_top_assert.svh"

module x64enc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_code_byte,
  input logic       out_last_byte,
  input logic       out_range_error
);

  `X64ENC_ASSERT_NOW(a_err_beat, out_valid && out_range_error, out_last_byte && out_code_byte == 8'd0, "range error beat must be a lone zero byte")
  `X64ENC_ASSERT_NEXT(a_more_bytes, out_valid && !out_stall && !out_last_byte, out_valid, "bytes of one instruction must follow without a gap")
  `X64ENC_ASSERT_NOW(a_stall_cause, in_stall, out_valid, "input stalled with an empty byte buffer")
  `X64ENC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_code_byte) && $stable(out_last_byte) && $stable(out_range_error), "stalled output beat changed")

endmodule

bind x86_64_instruction_encoder_top x64enc_checker u_x64enc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_code_byte   (out_code_byte),
  .out_last_byte   (out_last_byte),
  .out_range_error (out_range_error)
);
